// File: design/csk_pkg.sv
package csk_pkg;

    localparam int LINE_W = 32;

    localparam logic [7:0] LOW_LIMIT  = 8'd64;
    localparam logic [7:0] BYTE_SLASH = 8'h2F;
    localparam logic [7:0] BYTE_HASH  = 8'h23;
    localparam logic [7:0] BYTE_STAR  = 8'h2A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_TAB   = 8'h09;

    typedef enum logic [2:0] {
        ST_DEFAULT,
        ST_SLASH,
        ST_LINE,
        ST_BLOCK,
        ST_STAR
    } scan_state_t;

    typedef enum logic [2:0] {
        CL_SLASH,
        CL_HASH,
        CL_STAR,
        CL_EOL,
        CL_SPACE,
        CL_OTHER
    } byte_class_t;

    typedef enum logic [1:0] {
        ACT_SKIP,
        ACT_STOP,
        ACT_STOP_SLASH
    } action_t;

    typedef struct packed {
        scan_state_t        scan_state;
        logic               cr_pending;
        logic [LINE_W-1:0]  line_count;
    } scan_ctx_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t cl;
        if (b >= LOW_LIMIT) begin
            cl = CL_OTHER;
        end else if (b == BYTE_SLASH) begin
            cl = CL_SLASH;
        end else if (b == BYTE_HASH) begin
            cl = CL_HASH;
        end else if (b == BYTE_STAR) begin
            cl = CL_STAR;
        end else if (b == BYTE_LF || b == BYTE_CR) begin
            cl = CL_EOL;
        end else if (b == BYTE_SPACE || b == BYTE_TAB) begin
            cl = CL_SPACE;
        end else begin
            cl = CL_OTHER;
        end
        return cl;
    endfunction

endpackage

// File: design/comment_whitespace_skipper.sv
// Comment and whitespace skipper. Feed one text byte per request on s_*; each byte
// returns one result on m_*: m_action 0 = skipped, 1 = stop at this byte (not
// consumed), 2 = stop and put back a slash in front of it. m_line_number is the
// line count after the byte, starting at 1, counting LF or CR once (CR LF counts
// once) and wrapping at 2^32. One byte is taken every cycle while m_ready is high;
// each taken byte passes from the input register to the result register, with the
// scan state updated by the combinational csk_step logic in between. The input
// stalls only while a result waits on m_ready.
module comment_whitespace_skipper import csk_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_text_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_action,
    output logic [LINE_W-1:0] m_line_number
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    action_t           out_action_reg;
    logic [LINE_W-1:0] out_line_reg;
    scan_ctx_t         ctx_reg;
    scan_ctx_t         ctx_next;
    action_t           step_action;
    logic              advance;

    csk_step u_step (
        .text_byte (in_byte_reg),
        .ctx       (ctx_reg),
        .ctx_next  (ctx_next),
        .action    (step_action)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            ctx_reg.scan_state  <= ST_DEFAULT;
            ctx_reg.cr_pending  <= 1'b0;
            ctx_reg.line_count  <= LINE_W'(1);
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                ctx_reg       <= ctx_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_text_byte;
        end
        if (advance) begin
            out_action_reg <= step_action;
            out_line_reg   <= ctx_next.line_count;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_action      = out_action_reg;
    assign m_line_number = out_line_reg;

    a_stop_returns_default: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && step_action != ACT_SKIP |=> ctx_reg.scan_state == ST_DEFAULT)
        else $error("scan state not default after stop");

    a_line_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(ctx_reg.line_count))
        else $error("line count moved without a request");

    a_line_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> ctx_reg.line_count == $past(ctx_reg.line_count)
            || ctx_reg.line_count == $past(ctx_reg.line_count) + LINE_W'(1))
        else $error("line count stepped by more than one");

endmodule

// File: design/csk_step.sv
module csk_step import csk_pkg::*; (
    input  logic [7:0]        text_byte,
    input  scan_ctx_t         ctx,
    output scan_ctx_t         ctx_next,
    output action_t           action
);

    byte_class_t cl;
    scan_state_t nx_state;
    logic        stop;
    logic        stop_slash;

    assign cl = classify(text_byte);

    always_comb begin
        nx_state   = ST_DEFAULT;
        stop       = 1'b0;
        stop_slash = 1'b0;
        case (ctx.scan_state)
            ST_SLASH: begin
                case (cl)
                    CL_SLASH: nx_state = ST_LINE;
                    CL_STAR:  nx_state = ST_BLOCK;
                    default:  stop_slash = 1'b1;
                endcase
            end
            ST_LINE: begin
                nx_state = (cl == CL_EOL) ? ST_DEFAULT : ST_LINE;
            end
            ST_BLOCK: begin
                nx_state = (cl == CL_STAR) ? ST_STAR : ST_BLOCK;
            end
            ST_STAR: begin
                case (cl)
                    CL_SLASH: nx_state = ST_DEFAULT;
                    CL_STAR:  nx_state = ST_STAR;
                    default:  nx_state = ST_BLOCK;
                endcase
            end
            default: begin
                case (cl)
                    CL_SLASH: nx_state = ST_SLASH;
                    CL_HASH:  nx_state = ST_LINE;
                    CL_EOL:   nx_state = ST_DEFAULT;
                    CL_SPACE: nx_state = ST_DEFAULT;
                    default:  stop = 1'b1;
                endcase
            end
        endcase
    end

    always_comb begin
        ctx_next            = ctx;
        ctx_next.cr_pending = 1'b0;
        action              = ACT_SKIP;
        // swallow LF right after a skipped CR
        if (!(ctx.cr_pending && text_byte == BYTE_LF)) begin
            if (stop || stop_slash) begin
                action              = stop ? ACT_STOP : ACT_STOP_SLASH;
                ctx_next.scan_state = ST_DEFAULT;
            end else begin
                ctx_next.scan_state = nx_state;
                if (cl == CL_EOL) begin
                    ctx_next.line_count = ctx.line_count + LINE_W'(1);
                    ctx_next.cr_pending = (text_byte == BYTE_CR);
                end
            end
        end
    end

endmodule
